[sv/tcsb_pkg.sv]
// Shared types and constants for the text console scroll buffer.
// No dependencies; every other file imports this package.
`default_nettype none

package tcsb_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;
  localparam int TAB_WIDTH   = 2;
  localparam int CELL_CAP    = MAX_COLUMNS * MAX_ROWS;
  localparam int CELL_AW     = $clog2(CELL_CAP);
  localparam int FILL_W      = CELL_AW + 1;
  localparam int REP_W       = $clog2(TAB_WIDTH + 1);
  localparam int MOD_STEPS   = FILL_W;
  localparam int MOD_CW      = $clog2(MOD_STEPS);

  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_CTRL_MAX = 8'd27;

  localparam logic [7:0] COLS_RESET = 8'd79;
  localparam logic [6:0] ROWS_RESET = 7'd30;
  localparam logic [7:0] BS_RESET   = 8'd8;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_COLS = 2'd0,
    REG_ROWS = 2'd1,
    REG_BS   = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUT,
    ST_COL,
    ST_LINE,
    ST_SCROLL,
    ST_AMUL,
    ST_AMOD,
    ST_AWAIT,
    ST_NLW,
    ST_PW,
    ST_RD,
    ST_RDW,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [12:0] view_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_char;
    logic [13:0] fill_level;
    logic [6:0]  cursor_row;
    logic [5:0]  top_row;
    logic        scrolled;
    logic        redraw_needed;
  } out_item_t;

  // effective geometry (already saturated) and backspace code
  typedef struct packed {
    logic [7:0] cols;
    logic [6:0] rows;
    logic [7:0] bs;
  } cfg_t;

  typedef struct packed {
    logic [CELL_AW-1:0] addr;
    logic               we;
    logic [7:0]         wdata;
  } ram_req_t;

endpackage

`default_nettype wire

[sv/tcsb_mod_unit.sv]
// Iterative remainder unit: dividend mod divisor, one bit per cycle.
// Depends on tcsb_pkg.
`default_nettype none

module tcsb_mod_unit
  import tcsb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [FILL_W-1:0] dividend,
  input  wire logic [FILL_W-1:0] divisor,
  output logic                   done,
  output logic [CELL_AW-1:0]     rem
);

  logic [FILL_W-1:0] rem_r, rem_nxt;
  logic [FILL_W-1:0] dvd_r, dvd_nxt;
  logic [FILL_W-1:0] div_r, div_nxt;
  logic [MOD_CW-1:0] cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [FILL_W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[FILL_W-1]};
    if (start) begin
      rem_nxt = '0;
      dvd_nxt = dividend;
      div_nxt = divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      // restoring step; remainder stays below divisor
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = FILL_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[FILL_W-1:0];
      end
      dvd_nxt = {dvd_r[FILL_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MOD_CW'(MOD_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[CELL_AW-1:0];

endmodule

`default_nettype wire

[sv/tcsb_cell_ram.sv]
// Character cell store: single-port synchronous RAM, registered read.
// Depends on tcsb_pkg.
`default_nettype none

module tcsb_cell_ram
  import tcsb_pkg::*;
(
  input  wire logic     clk,
  input  wire ram_req_t req,
  output logic [7:0]    rdata
);

  logic [7:0] mem [CELL_CAP];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata_r <= mem[req.addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[sv/tcsb_engine.sv]
// Sequencer for put/read/clear items: counters, column math, ring
// addressing and cell writes. Depends on tcsb_pkg, tcsb_mod_unit.
`default_nettype none

module tcsb_engine
  import tcsb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_item,
  input  wire cfg_t       cfg,
  output ram_req_t        ram_req,
  input  wire logic [7:0] ram_rdata,
  output logic            out_strobe,
  output out_item_t       out_item
);

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [7:0]         code_r, code_nxt;
  logic [12:0]        view_r, view_nxt;
  logic [REP_W-1:0]   rep_r, rep_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [6:0]         cursor_r, cursor_nxt;
  logic [5:0]         top_r, top_nxt;
  logic [14:0]        prod_r, prod_nxt;
  logic [FILL_W-1:0]  tot_r, tot_nxt;
  logic signed [15:0] col_r, col_nxt;
  logic [CELL_AW-1:0] addr_r, addr_nxt;
  logic [7:0]         cnt_r, cnt_nxt;
  logic               first_r, first_nxt;
  logic               scr_r, scr_nxt;
  logic               redraw_r, redraw_nxt;
  logic [7:0]         rd_r, rd_nxt;
  out_item_t          out_r, out_nxt;
  logic               strobe_r, strobe_nxt;

  logic               mod_start;
  logic [FILL_W-1:0]  mod_dvd;
  logic               mod_done;
  logic [CELL_AW-1:0] mod_rem;

  logic [14:0]        cur_prod, top_prod, tot_prod;
  logic [6:0]         top_inc;
  logic signed [15:0] cols_s;
  logic [FILL_W:0]    addr_inc;

  assign cur_prod = {8'd0, cursor_r} * {7'd0, cfg.cols};
  assign top_prod = {9'd0, top_r} * {7'd0, cfg.cols};
  assign tot_prod = {7'd0, cfg.cols} * {8'd0, cfg.rows};
  assign top_inc  = {1'b0, top_r} + 7'd1;
  assign cols_s   = $signed({8'd0, cfg.cols});
  assign addr_inc = {2'b00, addr_r} + 15'd1;

  tcsb_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (tot_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    code_nxt   = code_r;
    view_nxt   = view_r;
    rep_nxt    = rep_r;
    fill_nxt   = fill_r;
    cursor_nxt = cursor_r;
    top_nxt    = top_r;
    prod_nxt   = prod_r;
    tot_nxt    = tot_r;
    col_nxt    = col_r;
    addr_nxt   = addr_r;
    cnt_nxt    = cnt_r;
    first_nxt  = first_r;
    scr_nxt    = scr_r;
    redraw_nxt = redraw_r;
    rd_nxt     = rd_r;
    out_nxt    = out_r;
    strobe_nxt = 1'b0;
    mod_start  = 1'b0;
    mod_dvd    = (op_r == OP_READ) ? ({1'b0, view_r} + prod_r[FILL_W-1:0])
                                   : (fill_r + prod_r[FILL_W-1:0]);
    ram_req.addr  = addr_r;
    ram_req.we    = 1'b0;
    ram_req.wdata = code_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt     = op_t'(in_item.operation);
          code_nxt   = (in_item.char_code == CH_CR) ? CH_LF : in_item.char_code;
          view_nxt   = in_item.view_index;
          rep_nxt    = '0;
          scr_nxt    = 1'b0;
          redraw_nxt = 1'b0;
          rd_nxt     = '0;
          unique case (op_t'(in_item.operation))
            OP_PUT:  state_nxt = ST_PUT;
            OP_READ: state_nxt = ST_AMUL;
            OP_CLEAR: begin
              fill_nxt   = '0;
              top_nxt    = '0;
              cursor_nxt = '0;
              redraw_nxt = 1'b1;
              state_nxt  = ST_DONE;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      ST_PUT: begin
        // backspace test wins over every other meaning of the byte
        priority if (code_r == cfg.bs) begin
          if (fill_r != '0) begin
            fill_nxt   = fill_r - 1'b1;
            redraw_nxt = 1'b1;
          end
          state_nxt = ST_NEXT;
        end else if (code_r == CH_TAB) begin
          code_nxt  = CH_SPACE;
          rep_nxt   = REP_W'(TAB_WIDTH - 1);
          state_nxt = ST_PUT;
        end else if (code_r == CH_LF || code_r > CH_CTRL_MAX) begin
          prod_nxt  = cur_prod;
          state_nxt = ST_COL;
        end else begin
          state_nxt = ST_NEXT;
        end
      end

      ST_COL: begin
        col_nxt   = $signed({2'b00, fill_r}) - $signed({1'b0, prod_r});
        state_nxt = ST_LINE;
      end

      ST_LINE: begin
        if (code_r == CH_LF) begin
          if (!col_r[15] && col_r < cols_s) begin
            cnt_nxt   = cfg.cols - col_r[7:0];
            first_nxt = 1'b1;
            state_nxt = ST_AMUL;
          end else begin
            // column out of range: no cells, row still advances
            cursor_nxt = cursor_r + 7'd1;
            state_nxt  = ST_SCROLL;
          end
        end else begin
          if (col_r + 16'sd1 == cols_s) begin
            cursor_nxt = cursor_r + 7'd1;
          end
          state_nxt = ST_SCROLL;
        end
      end

      ST_SCROLL: begin
        if (cursor_r >= cfg.rows) begin
          cursor_nxt = cursor_r - 7'd1;
          top_nxt    = (top_inc >= cfg.rows) ? 6'd0 : top_inc[5:0];
          fill_nxt   = (fill_r > {6'd0, cfg.cols}) ? fill_r - {6'd0, cfg.cols} : '0;
          scr_nxt    = 1'b1;
          redraw_nxt = 1'b1;
        end
        state_nxt = (code_r == CH_LF) ? ST_NEXT : ST_AMUL;
      end

      ST_AMUL: begin
        prod_nxt  = top_prod;
        tot_nxt   = tot_prod[FILL_W-1:0];
        state_nxt = ST_AMOD;
      end

      ST_AMOD: begin
        mod_start = 1'b1;
        state_nxt = ST_AWAIT;
      end

      ST_AWAIT: begin
        if (mod_done) begin
          addr_nxt = mod_rem;
          priority if (op_r == OP_READ) begin
            state_nxt = ST_RD;
          end else if (code_r == CH_LF) begin
            state_nxt = ST_NLW;
          end else begin
            state_nxt = ST_PW;
          end
        end
      end

      ST_NLW: begin
        // newline fill: newline code in the first cell, zero after
        ram_req.we    = 1'b1;
        ram_req.wdata = first_r ? CH_LF : 8'd0;
        first_nxt     = 1'b0;
        if (fill_r < FILL_W'(CELL_CAP)) begin
          fill_nxt = fill_r + 1'b1;
          addr_nxt = (addr_inc[FILL_W-1:0] == tot_r) ? '0 : addr_inc[CELL_AW-1:0];
        end
        cnt_nxt = cnt_r - 8'd1;
        if (cnt_r == 8'd1) begin
          cursor_nxt = cursor_r + 7'd1;
          state_nxt  = ST_SCROLL;
        end
      end

      ST_PW: begin
        ram_req.we = 1'b1;
        if (fill_r < FILL_W'(CELL_CAP)) begin
          fill_nxt = fill_r + 1'b1;
        end
        state_nxt = ST_NEXT;
      end

      ST_RD: begin
        state_nxt = ST_RDW;
      end

      ST_RDW: begin
        rd_nxt    = ram_rdata;
        state_nxt = ST_DONE;
      end

      ST_NEXT: begin
        if (rep_r != '0) begin
          rep_nxt   = rep_r - 1'b1;
          state_nxt = ST_PUT;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        out_nxt.read_char     = rd_r;
        out_nxt.fill_level    = fill_r;
        out_nxt.cursor_row    = cursor_r;
        out_nxt.top_row       = top_r;
        out_nxt.scrolled      = scr_r;
        out_nxt.redraw_needed = redraw_r;
        strobe_nxt            = 1'b1;
        state_nxt             = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      cursor_r <= '0;
      top_r    <= '0;
      rep_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      cursor_r <= cursor_nxt;
      top_r    <= top_nxt;
      rep_r    <= rep_nxt;
      strobe_r <= strobe_nxt;
    end
    op_r     <= op_nxt;
    code_r   <= code_nxt;
    view_r   <= view_nxt;
    prod_r   <= prod_nxt;
    tot_r    <= tot_nxt;
    col_r    <= col_nxt;
    addr_r   <= addr_nxt;
    cnt_r    <= cnt_nxt;
    first_r  <= first_nxt;
    scr_r    <= scr_nxt;
    redraw_r <= redraw_nxt;
    rd_r     <= rd_nxt;
    out_r    <= out_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

endmodule

`default_nettype wire

[sv/text_console_scroll_buffer.sv]
// Text console scroll buffer: ring of character rows in one 8192-cell RAM. Uses tcsb_pkg.
// Clear and no-op go straight to the result; backspace and ignored bytes touch no RAM;
// reads and printable puts first reduce the ring address with the bit-serial remainder unit;
// a newline writes one cell per remaining column (none when out of range); a tab puts two spaces.
// One item at a time: next start taken at the edge ending the strobe cycle;
// results cannot be stalled. Sync rst_n clears counters, loads register defaults; no RAM clear.
`default_nettype none

module text_console_scroll_buffer
  import tcsb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // item channel
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  // result channel
  output logic             out_strobe,
  output out_item_t        out_item,
  // APB register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // configuration registers, raw as written
  logic [7:0] cols_r, cols_nxt;
  logic [6:0] rows_r, rows_nxt;
  logic [7:0] bs_r, bs_nxt;
  logic       wr_en;
  reg_idx_t   wr_idx;
  cfg_t       cfg;
  ram_req_t   ram_req;
  logic [7:0] ram_rdata;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    bs_nxt   = bs_r;
    if (wr_en) begin
      unique case (wr_idx)
        REG_COLS: cols_nxt = pwdata[7:0];
        REG_ROWS: rows_nxt = pwdata[6:0];
        REG_BS:   bs_nxt   = pwdata[7:0];
        default:  ;  // unmapped address: write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
      rows_r <= ROWS_RESET;
      bs_r   <= BS_RESET;
    end else begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
      bs_r   <= bs_nxt;
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_COLS: prdata = {24'd0, cols_r};
      REG_ROWS: prdata = {25'd0, rows_r};
      REG_BS:   prdata = {24'd0, bs_r};
      default:  prdata = '0;
    endcase
  end

  // geometry saturated into its legal range before the engine sees it
  always_comb begin
    priority if (cols_r == 8'd0) begin
      cfg.cols = 8'd1;
    end else if ({1'b0, cols_r} > 9'(MAX_COLUMNS)) begin
      cfg.cols = 8'(MAX_COLUMNS);
    end else begin
      cfg.cols = cols_r;
    end
    priority if (rows_r == 7'd0) begin
      cfg.rows = 7'd1;
    end else if ({1'b0, rows_r} > 8'(MAX_ROWS)) begin
      cfg.rows = 7'(MAX_ROWS);
    end else begin
      cfg.rows = rows_r;
    end
    cfg.bs = bs_r;
  end

  tcsb_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .cfg        (cfg),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // cell store, addressed by ring position
  tcsb_cell_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
